/* hw/rtl/averaged_sensor_pi_pwm_loop_defines.svh */
// Assertion macros shared by the averaged sensor PI PWM loop RTL.
// Expects signals named clock and reset in the scope of each use.
`ifndef AVERAGED_SENSOR_PI_PWM_LOOP_DEFINES_SVH
`define AVERAGED_SENSOR_PI_PWM_LOOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ASPL_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define ASPL_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`define ASPL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define ASPL_ASSERT_ALWAYS(lbl, cond, msg)
`define ASPL_ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASPL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/aspl_pkg.sv */
// Package for the averaged sensor PI PWM loop: field widths, fixed-point
// constants, register indexes and the sequencer-to-datapath op codes.
package aspl_pkg;

   localparam int ADC_W      = 12;
   localparam int ADC_KEEP_W = 10;
   localparam int ADC_MAX    = 1023;
   localparam int PCT_W      = 7;
   localparam int PCT_SCALE  = 100;
   localparam int ERR_W      = 8;
   localparam int GAIN_W     = 16;
   localparam int PERIOD_W   = 16;
   localparam int FRAC_BITS  = 14;
   localparam int DRIVE_W    = 21;
   localparam int ACC_W      = 27;
   localparam int MUL_G_W    = GAIN_W + ERR_W;
   localparam int PULSE_W    = 16;

   // raw * 100 / 1023: multiply by 1025 / 2^20, then one correction step
   localparam int SCALE_W      = 17;
   localparam int SCALE_PROD_W = 27;
   localparam int SCALE_SHIFT  = 20;

   localparam logic [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(PCT_SCALE << FRAC_BITS);

   // floor(x / 100) for x < 2^23 as (x * ceil(2^30 / 100)) >> 30
   localparam int PWM_PROD_W  = PERIOD_W + DRIVE_W;
   localparam int PWM_Q_W     = PWM_PROD_W - FRAC_BITS;
   localparam int PWM_RECIP_W = 24;
   localparam int PWM_SHIFT   = 30;
   localparam int PWM_DIV_W   = PWM_Q_W + PWM_RECIP_W;
   localparam logic [PWM_RECIP_W-1:0] PWM_RECIP =
      PWM_RECIP_W'(((1 << PWM_SHIFT) + PCT_SCALE - 1) / PCT_SCALE);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [PCT_W-1:0]           SETPOINT_RST  = 7'd40;
   localparam logic signed [GAIN_W-1:0]   GAIN_NOW_RST  = 16'sd1229;
   localparam logic signed [GAIN_W-1:0]   GAIN_PREV_RST = -16'sd819;
   localparam logic [PERIOD_W-1:0]        PERIOD_RST    = 16'd100;

   typedef enum logic [1:0] {
      REG_SETPOINT   = 2'd0,
      REG_GAIN_NOW   = 2'd1,
      REG_GAIN_PREV  = 2'd2,
      REG_PWM_PERIOD = 2'd3
   } reg_idx_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCALE,
      OP_SHIFT,
      OP_MEAN,
      OP_MUL_NOW,
      OP_MUL_PREV,
      OP_CLAMP,
      OP_PWM_MUL,
      OP_PWM_DIV,
      OP_OUT
   } op_type;

endpackage

/* hw/rtl/aspl_csr.sv */
// Configuration registers of the averaged sensor PI PWM loop, APB-style access.
// Depends on aspl_pkg.
module aspl_csr
   import aspl_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [CSR_DATA_W-1:0]       csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready,
   output logic [PCT_W-1:0]            setpoint,
   output logic signed [GAIN_W-1:0]    gain_now,
   output logic signed [GAIN_W-1:0]    gain_prev,
   output logic [PERIOD_W-1:0]         pwm_period
);

   logic                     wr_en;
   reg_idx_type              reg_idx;
   logic [PCT_W-1:0]         setpoint_ff;
   logic signed [GAIN_W-1:0] gain_now_ff;
   logic signed [GAIN_W-1:0] gain_prev_ff;
   logic [PERIOD_W-1:0]      period_ff;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff  <= SETPOINT_RST;
         gain_now_ff  <= GAIN_NOW_RST;
         gain_prev_ff <= GAIN_PREV_RST;
         period_ff    <= PERIOD_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_SETPOINT:   setpoint_ff  <= csr_pwdata[PCT_W-1:0];
            REG_GAIN_NOW:   gain_now_ff  <= csr_pwdata[GAIN_W-1:0];
            REG_GAIN_PREV:  gain_prev_ff <= csr_pwdata[GAIN_W-1:0];
            REG_PWM_PERIOD: period_ff    <= csr_pwdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SETPOINT:   csr_prdata = CSR_DATA_W'(setpoint_ff);
         REG_GAIN_NOW:   csr_prdata = CSR_DATA_W'(unsigned'(gain_now_ff));
         REG_GAIN_PREV:  csr_prdata = CSR_DATA_W'(unsigned'(gain_prev_ff));
         REG_PWM_PERIOD: csr_prdata = CSR_DATA_W'(period_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign setpoint   = setpoint_ff;
   assign gain_now   = gain_now_ff;
   assign gain_prev  = gain_prev_ff;
   assign pwm_period = period_ff;

endmodule

/* hw/rtl/aspl_ctrl.sv */
// Sequencer of the averaged sensor PI PWM loop: steps one beat through the
// datapath ops and owns both handshakes. Depends on aspl_pkg and the defines.
`include "averaged_sensor_pi_pwm_loop_defines.svh"
module aspl_ctrl
   import aspl_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   req_valid,
   output logic   req_stall,
   output logic   rsp_valid,
   input  logic   rsp_stall,
   output op_type op
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_SHIFT,
      ST_MEAN,
      ST_MUL_NOW,
      ST_MUL_PREV,
      ST_CLAMP,
      ST_PWM_MUL,
      ST_PWM_DIV,
      ST_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      op       = OP_NONE;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            op       = OP_SCALE;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            op       = OP_SHIFT;
            state_in = ST_MEAN;
         end
         ST_MEAN: begin
            op       = OP_MEAN;
            state_in = ST_MUL_NOW;
         end
         ST_MUL_NOW: begin
            op       = OP_MUL_NOW;
            state_in = ST_MUL_PREV;
         end
         ST_MUL_PREV: begin
            op       = OP_MUL_PREV;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            op       = OP_CLAMP;
            state_in = ST_PWM_MUL;
         end
         ST_PWM_MUL: begin
            op       = OP_PWM_MUL;
            state_in = ST_PWM_DIV;
         end
         ST_PWM_DIV: begin
            op       = OP_PWM_DIV;
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               op       = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (op == OP_OUT) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ASPL_ASSERT_NEXT(a_accept_starts_seq, req_valid && !req_stall, state_ff == ST_SCALE, "accepted beat did not start the sequence")
   `ASPL_ASSERT_IMPLY(a_out_slot_free, op == OP_OUT, !rsp_valid_ff || !rsp_stall, "result overwrote a stalled beat")

endmodule

/* hw/rtl/aspl_dp.sv */
// Datapath of the averaged sensor PI PWM loop: sample scaling, averaging window,
// incremental PI law, clamp, PWM scaling and result register. Depends on aspl_pkg.
`include "averaged_sensor_pi_pwm_loop_defines.svh"
module aspl_dp
   import aspl_pkg::*;
#(
   parameter int WINDOW_DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  op_type                    op,
   input  logic [ADC_W-1:0]          req_adc_raw,
   input  logic                      req_sample_ok,
   input  logic [PCT_W-1:0]          setpoint,
   input  logic signed [GAIN_W-1:0]  gain_now,
   input  logic signed [GAIN_W-1:0]  gain_prev,
   input  logic [PERIOD_W-1:0]       pwm_period,
   output logic [PULSE_W-1:0]        rsp_pulse_width,
   output logic [PCT_W-1:0]          rsp_drive_percent,
   output logic signed [ERR_W-1:0]   rsp_loop_error,
   output logic [PCT_W-1:0]          rsp_feedback_level,
   output logic                      rsp_sample_rejected
);

   // mean = (sum * ceil(2^K / depth)) >> K, exact for every reachable sum
   localparam int DEPTH_LOG  = $clog2(WINDOW_DEPTH);
   localparam int SUM_W      = PCT_W + DEPTH_LOG;
   localparam int MEAN_SHIFT = SUM_W + DEPTH_LOG;
   localparam int MEAN_MUL_W = MEAN_SHIFT + 1;
   localparam int MEAN_PROD_W = SUM_W + MEAN_MUL_W;
   localparam logic [MEAN_MUL_W-1:0] MEAN_MUL =
      MEAN_MUL_W'(((1 << MEAN_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH);
   localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(WINDOW_DEPTH * PCT_SCALE);

   logic [ADC_W-1:0]          raw_ff;
   logic                      rej_ff;
   logic [SCALE_W-1:0]        x_ff;
   logic [PCT_W-1:0]          q0_ff;
   logic [PCT_W-1:0]          win_ff [WINDOW_DEPTH];
   logic [PCT_W-1:0]          win_in [WINDOW_DEPTH];
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [PCT_W-1:0]          fb_ff;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [ERR_W-1:0]   last_err_ff;
   logic [DRIVE_W-1:0]        last_drive_ff, drive_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic [PWM_PROD_W-1:0]     pprod_ff;
   logic [PULSE_W-1:0]        pulse_ff;

   logic [PULSE_W-1:0]        out_pulse_ff;
   logic [PCT_W-1:0]          out_drive_ff;
   logic signed [ERR_W-1:0]   out_err_ff;
   logic [PCT_W-1:0]          out_fb_ff;
   logic                      out_rej_ff;

   logic [SCALE_W-1:0]        x_in;
   logic [SCALE_PROD_W-1:0]   recip_prod;
   logic [SCALE_W-1:0]        q0_times_max;
   logic [SCALE_W-1:0]        rem;
   logic [PCT_W-1:0]          q;
   logic [MEAN_PROD_W-1:0]    mean_prod;
   logic [PCT_W-1:0]          mean;
   logic [PCT_W-1:0]          fb_in;
   logic [ERR_W-1:0]          err_in;
   logic signed [MUL_G_W-1:0] mul_now;
   logic signed [MUL_G_W-1:0] mul_prev;
   logic [PWM_DIV_W-1:0]      pwm_div_prod;

   assign x_in       = SCALE_W'(raw_ff[ADC_KEEP_W-1:0]) * SCALE_W'(PCT_SCALE);
   assign recip_prod = (SCALE_PROD_W'(x_in) << ADC_KEEP_W) + SCALE_PROD_W'(x_in);

   assign q0_times_max = (SCALE_W'(q0_ff) << ADC_KEEP_W) - SCALE_W'(q0_ff);
   assign rem          = x_ff - q0_times_max;
   assign q            = q0_ff + PCT_W'(rem >= SCALE_W'(ADC_MAX));

   always_comb begin
      win_in[0] = q;
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
         win_in[i] = win_ff[i-1];
      end
      sum_in = sum_ff + SUM_W'(q) - SUM_W'(win_ff[WINDOW_DEPTH-1]);
   end

   assign mean_prod = MEAN_PROD_W'(sum_ff) * MEAN_PROD_W'(MEAN_MUL);
   assign mean      = PCT_W'(mean_prod >> MEAN_SHIFT);
   assign fb_in     = PCT_W'(PCT_SCALE) - mean;
   assign err_in    = ERR_W'(setpoint) - ERR_W'(fb_in);

   assign mul_now  = gain_now * err_ff;
   assign mul_prev = gain_prev * last_err_ff;

   always_comb begin
      if (acc_ff < 0) begin
         drive_in = '0;
      end else if (acc_ff > ACC_W'(DRIVE_MAX)) begin
         drive_in = DRIVE_MAX;
      end else begin
         drive_in = acc_ff[DRIVE_W-1:0];
      end
   end

   assign pwm_div_prod = PWM_DIV_W'(pprod_ff[PWM_PROD_W-1:FRAC_BITS]) * PWM_DIV_W'(PWM_RECIP);

   // loop state: cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            win_ff[i] <= '0;
         end
         sum_ff        <= '0;
         last_err_ff   <= '0;
         last_drive_ff <= '0;
      end else begin
         if (op == OP_SHIFT && !rej_ff) begin
            win_ff <= win_in;
            sum_ff <= sum_in;
         end
         if (op == OP_CLAMP) begin
            last_err_ff   <= err_ff;
            last_drive_ff <= drive_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         OP_LOAD: begin
            raw_ff <= req_adc_raw;
            rej_ff <= !req_sample_ok || (req_adc_raw > ADC_W'(ADC_MAX));
         end
         OP_SCALE: begin
            x_ff  <= x_in;
            q0_ff <= PCT_W'(recip_prod >> SCALE_SHIFT);
         end
         OP_MEAN: begin
            fb_ff  <= fb_in;
            err_ff <= signed'(err_in);
         end
         OP_MUL_NOW:  acc_ff <= ACC_W'(mul_now) + signed'(ACC_W'(last_drive_ff));
         OP_MUL_PREV: acc_ff <= acc_ff + ACC_W'(mul_prev);
         OP_PWM_MUL:  pprod_ff <= PWM_PROD_W'(pwm_period) * PWM_PROD_W'(last_drive_ff);
         OP_PWM_DIV:  pulse_ff <= pwm_div_prod[PWM_SHIFT +: PULSE_W];
         OP_OUT: begin
            out_pulse_ff <= pulse_ff;
            out_drive_ff <= last_drive_ff[FRAC_BITS +: PCT_W];
            out_err_ff   <= err_ff;
            out_fb_ff    <= fb_ff;
            out_rej_ff   <= rej_ff;
         end
         default: ;
      endcase
   end

   assign rsp_pulse_width     = out_pulse_ff;
   assign rsp_drive_percent   = out_drive_ff;
   assign rsp_loop_error      = out_err_ff;
   assign rsp_feedback_level  = out_fb_ff;
   assign rsp_sample_rejected = out_rej_ff;

   `ASPL_ASSERT_ALWAYS(a_drive_limit, last_drive_ff <= DRIVE_MAX, "stored drive above full scale")
   `ASPL_ASSERT_ALWAYS(a_sum_limit, sum_ff <= SUM_LIMIT, "window sum out of range")
   `ASPL_ASSERT_NEXT(a_reject_keeps_sum, op == OP_SHIFT && rej_ff, $stable(sum_ff), "rejected sample changed the window")

endmodule

/* hw/rtl/averaged_sensor_pi_pwm_loop.sv */
// Top level of the averaged sensor PI PWM loop: registers, sequencer, datapath.
// Depends on aspl_pkg, aspl_csr, aspl_ctrl and aspl_dp.
//
// One request beat carries a raw converter reading and its success flag; each
// beat yields exactly one response beat. A good reading of at most 1023 is
// scaled to percent and pushed into a WINDOW_DEPTH-deep averaging window; the
// window mean sets the feedback level, and an incremental PI law with 14
// fraction bits updates the drive, clamped to 0..100, which sets the PWM high
// time. Beats are handled one at a time: the sequencer walks each through
// scaling, window update, mean, two gain products, clamp and two PWM scaling
// steps on a single datapath, and the next beat is accepted only once the
// previous one has been moved to the output register. A finished response
// waits in an output register while the next beat is already accepted; a
// response still stalled when the next one is ready holds the sequencer in
// its last step. Configuration must be written through the csr_ port only
// while no beat is in flight; the block itself does not enforce this.
module averaged_sensor_pi_pwm_loop
   import aspl_pkg::*;
#(
   parameter int WINDOW_DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ADC_W-1:0]         req_adc_raw,
   input  logic                     req_sample_ok,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [PULSE_W-1:0]       rsp_pulse_width,
   output logic [PCT_W-1:0]         rsp_drive_percent,
   output logic signed [ERR_W-1:0]  rsp_loop_error,
   output logic [PCT_W-1:0]         rsp_feedback_level,
   output logic                     rsp_sample_rejected,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [CSR_DATA_W-1:0]    csr_pwdata,
   output logic [CSR_DATA_W-1:0]    csr_prdata,
   output logic                     csr_pready
);

   logic [PCT_W-1:0]         setpoint;
   logic signed [GAIN_W-1:0] gain_now;
   logic signed [GAIN_W-1:0] gain_prev;
   logic [PERIOD_W-1:0]      pwm_period;
   op_type                   op;

   aspl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .setpoint    (setpoint),
      .gain_now    (gain_now),
      .gain_prev   (gain_prev),
      .pwm_period  (pwm_period)
   );

   aspl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .op        (op)
   );

   aspl_dp #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .op                  (op),
      .req_adc_raw         (req_adc_raw),
      .req_sample_ok       (req_sample_ok),
      .setpoint            (setpoint),
      .gain_now            (gain_now),
      .gain_prev           (gain_prev),
      .pwm_period          (pwm_period),
      .rsp_pulse_width     (rsp_pulse_width),
      .rsp_drive_percent   (rsp_drive_percent),
      .rsp_loop_error      (rsp_loop_error),
      .rsp_feedback_level  (rsp_feedback_level),
      .rsp_sample_rejected (rsp_sample_rejected)
   );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for averaged_sensor_pi_pwm_loop: sample beats in, loop results out.
// An internal predictor of the window average and PI update checks every response beat.
// Depends on aspl_pkg and the averaged_sensor_pi_pwm_loop RTL.
`timescale 1ns / 1ps

module tb_top;
   import aspl_pkg::*;

   localparam int WINDOW_LEN = 4;
   localparam longint DRIVE_FULL = longint'(PCT_SCALE) << FRAC_BITS;
   localparam int DIR_COUNT = 16;
   localparam logic [ADC_W-1:0] DIR_RAW [DIR_COUNT] = '{
      12'd0, 12'd1023, 12'd1024, 12'd4095, 12'd4095, 12'd512, 12'd1, 12'd1022,
      12'd2048, 12'd11, 12'd1000, 12'd0, 12'd1023, 12'd3072, 12'd10, 12'd1023};
   localparam logic DIR_OK [DIR_COUNT] = '{
      1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
      1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

   typedef struct packed {
      logic [PULSE_W-1:0]      pulse_width;
      logic [PCT_W-1:0]        drive_percent;
      logic signed [ERR_W-1:0] loop_error;
      logic [PCT_W-1:0]        feedback_level;
      logic                    sample_rejected;
   } loop_result_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_SPARSE,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   class pi_loop_checker;
      logic [PCT_W-1:0]         setpoint;
      logic signed [GAIN_W-1:0] gain_now;
      logic signed [GAIN_W-1:0] gain_prev;
      logic [PERIOD_W-1:0]      pwm_period;
      logic [PCT_W-1:0]         window [WINDOW_LEN];
      int                       last_error;
      longint                   last_drive;
      loop_result_type          pending_q [$];
      int                       errors;

      function new();
         setpoint   = SETPOINT_RST;
         gain_now   = GAIN_NOW_RST;
         gain_prev  = GAIN_PREV_RST;
         pwm_period = PERIOD_RST;
         foreach (window[i]) window[i] = '0;
         last_error = 0;
         last_drive = 0;
         errors     = 0;
      endfunction

      function void set_register(reg_idx_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_SETPOINT:   setpoint   = value[PCT_W-1:0];
            REG_GAIN_NOW:   gain_now   = value[GAIN_W-1:0];
            REG_GAIN_PREV:  gain_prev  = value[GAIN_W-1:0];
            REG_PWM_PERIOD: pwm_period = value[PERIOD_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      function void note_sample(logic [ADC_W-1:0] raw, logic ok);
         loop_result_type exp;
         int unsigned     sum;
         int              feedback;
         int              err;
         longint          drv;
         logic            rejected;
         int              i;
         rejected = !ok || (int'(raw) > ADC_MAX);
         if (!rejected) begin
            for (i = WINDOW_LEN - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = PCT_W'(int'(raw) * PCT_SCALE / ADC_MAX);
         end
         sum = 0;
         for (i = 0; i < WINDOW_LEN; i++) sum += window[i];
         feedback = PCT_SCALE - int'(sum / WINDOW_LEN);
         err = int'(setpoint) - feedback;
         drv = longint'(gain_now) * err + longint'(gain_prev) * last_error + last_drive;
         if (drv < 0) drv = 0;
         if (drv > DRIVE_FULL) drv = DRIVE_FULL;
         last_drive = drv;
         last_error = err;
         exp.pulse_width     = PULSE_W'((longint'(pwm_period) * drv) / DRIVE_FULL);
         exp.drive_percent   = PCT_W'(drv >>> FRAC_BITS);
         exp.loop_error      = ERR_W'(err);
         exp.feedback_level  = PCT_W'(feedback);
         exp.sample_rejected = rejected;
         pending_q.push_back(exp);
      endfunction

      function void check_output(loop_result_type got);
         loop_result_type exp;
         if (pending_q.size() == 0) begin
            $error("response beat with no expected result pending");
            errors++;
            return;
         end
         exp = pending_q.pop_front();
         if (got.pulse_width !== exp.pulse_width) begin
            $error("pulse_width expected %0d got %0d", exp.pulse_width, got.pulse_width);
            errors++;
         end
         if (got.drive_percent !== exp.drive_percent) begin
            $error("drive_percent expected %0d got %0d", exp.drive_percent, got.drive_percent);
            errors++;
         end
         if (got.loop_error !== exp.loop_error) begin
            $error("loop_error expected %0d got %0d", exp.loop_error, got.loop_error);
            errors++;
         end
         if (got.feedback_level !== exp.feedback_level) begin
            $error("feedback_level expected %0d got %0d", exp.feedback_level,
                   got.feedback_level);
            errors++;
         end
         if (got.sample_rejected !== exp.sample_rejected) begin
            $error("sample_rejected expected %0d got %0d", exp.sample_rejected,
                   got.sample_rejected);
            errors++;
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [ADC_W-1:0]        req_adc_raw = '0;
   logic                    req_sample_ok = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [PULSE_W-1:0]      rsp_pulse_width;
   logic [PCT_W-1:0]        rsp_drive_percent;
   logic signed [ERR_W-1:0] rsp_loop_error;
   logic [PCT_W-1:0]        rsp_feedback_level;
   logic                    rsp_sample_rejected;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   pi_loop_checker chk = new();
   int             csr_errors = 0;
   logic [7:0]     stall_cnt = '0;
   stall_mode_type stall_mode = STALL_NONE;

   averaged_sensor_pi_pwm_loop #(.WINDOW_DEPTH(WINDOW_LEN)) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_adc_raw         (req_adc_raw),
      .req_sample_ok       (req_sample_ok),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pulse_width     (rsp_pulse_width),
      .rsp_drive_percent   (rsp_drive_percent),
      .rsp_loop_error      (rsp_loop_error),
      .rsp_feedback_level  (rsp_feedback_level),
      .rsp_sample_rejected (rsp_sample_rejected),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // beats are sampled before this edge's updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) chk.note_sample(req_adc_raw, req_sample_ok);
         if (rsp_valid && !rsp_stall) begin
            chk.check_output('{rsp_pulse_width, rsp_drive_percent, rsp_loop_error,
                               rsp_feedback_level, rsp_sample_rejected});
         end
      end
   end

   always @(posedge clock) begin
      stall_cnt <= stall_cnt + 8'd1;
      if (stall_cnt == 8'hff) stall_mode <= stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_SPARSE:   rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_PERIODIC: rsp_stall <= (stall_cnt[3:0] < 4'd6);
         default:        rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_sample(input logic [ADC_W-1:0] raw, input logic ok);
      req_valid     <= 1'b1;
      req_adc_raw   <= raw;
      req_sample_ok <= ok;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic pick_sample(output logic [ADC_W-1:0] raw, output logic ok);
      int unsigned r;
      r = $urandom_range(0, 99);
      ok = 1'b1;
      if (r < 6) raw = (r < 3) ? ADC_W'(0) : ADC_W'(ADC_MAX);
      else if (r < 82) raw = ADC_W'($urandom_range(0, ADC_MAX));
      else if (r < 91) raw = ADC_W'($urandom_range(ADC_MAX + 1, 4095));
      else begin
         ok  = 1'b0;
         raw = ADC_W'($urandom_range(0, 4095));
      end
   endtask

   task automatic run_random(input int count);
      int          left;
      int          burst;
      int          gap;
      logic [ADC_W-1:0] raw;
      logic        ok;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         if (burst > left) burst = left;
         repeat (burst) begin
            pick_sample(raw, ok);
            send_sample(raw, ok);
         end
         left -= burst;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_outputs();
      req_valid <= 1'b0;
      @(posedge clock);
      while (chk.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input reg_idx_type idx,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_W'(int'(idx) * 4);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
   endtask

   task automatic write_register(input reg_idx_type idx, input int value, input int width);
      logic [CSR_DATA_W-1:0] rdata;
      logic [CSR_DATA_W-1:0] mask;
      mask = (CSR_DATA_W'(1) << width) - 1;
      csr_access(1'b1, idx, CSR_DATA_W'(value), rdata);
      chk.set_register(idx, CSR_DATA_W'(value));
      csr_access(1'b0, idx, '0, rdata);
      if ((rdata & mask) !== (CSR_DATA_W'(value) & mask)) begin
         $error("%s readback expected %0h got %0h", idx.name(),
                CSR_DATA_W'(value) & mask, rdata & mask);
         csr_errors++;
      end
   endtask

   task automatic apply_setting(input int sp, input int gn, input int gp, input int per);
      write_register(REG_SETPOINT, sp, PCT_W);
      write_register(REG_GAIN_NOW, gn, GAIN_W);
      write_register(REG_GAIN_PREV, gp, GAIN_W);
      write_register(REG_PWM_PERIOD, per, PERIOD_W);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int k;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < DIR_COUNT; k++) send_sample(DIR_RAW[k], DIR_OK[k]);
      run_random(200);
      drain_outputs();

      apply_setting(100, 16384, -8192, 65535);
      run_random(220);
      drain_outputs();
      apply_setting(0, 32767, -32768, 1);
      run_random(220);
      drain_outputs();
      apply_setting(127, -32768, 32767, 0);
      run_random(220);
      drain_outputs();
      apply_setting(50, 0, 0, 255);
      run_random(220);
      drain_outputs();
      for (k = 0; k < 3; k++) begin
         apply_setting($urandom_range(0, 127), int'($urandom_range(0, 65535)) - 32768,
                       int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 65535));
         run_random(220);
         drain_outputs();
      end
      apply_setting(40, 1229, -819, 100);
      run_random(200);
      drain_outputs();

      repeat (20) @(posedge clock);
      if (chk.errors == 0 && csr_errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/aspl_pkg.sv
hw/rtl/aspl_csr.sv
hw/rtl/aspl_ctrl.sv
hw/rtl/aspl_dp.sv
hw/rtl/averaged_sensor_pi_pwm_loop.sv
sim/tb_top.sv
